// ===== design/cfir_pkg.sv =====
// shared types and constants for the complex fir filter
`default_nettype none

package cfir_pkg;

    // fixed field widths
    localparam int ACC_W     = 40;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W     = 2 * ACC_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_TAPS = 1'b1;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 7'd1;

    // action codes carried in tuser
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear_en;
        logic load_we;
        logic push_we;
        logic start;
        logic rd_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic n_zero;
        logic rd_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/cfir_ram.sv =====
// generic ram, one write port, one registered read port
`default_nettype none

module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/cfir_ctrl.sv =====
// sequencer for the complex fir filter
`default_nettype none

module cfir_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_valid,
    input  wire logic                   i_action,
    output logic                        o_s_ready,
    output cfir_pkg::t_dp_cmd           o_cmd,
    input  wire cfir_pkg::t_dp_status   i_status
);

    cfir_pkg::t_state r_state;
    cfir_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfir_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            cfir_pkg::S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = cfir_pkg::S_IDLE;
                end
            end
            cfir_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_action == cfir_pkg::ACT_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.push_we = 1'b1;
                        n_state       = cfir_pkg::S_START;
                    end
                end
            end
            cfir_pkg::S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_status.n_zero ? cfir_pkg::S_DRAIN : cfir_pkg::S_RUN;
            end
            cfir_pkg::S_RUN: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.rd_last) begin
                    n_state = cfir_pkg::S_DRAIN;
                end
            end
            cfir_pkg::S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = cfir_pkg::S_OUT;
                end
            end
            cfir_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cfir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfir_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/cfir_dp.sv =====
// datapath: tap and sample stores, complex multiply-accumulate, output register
`default_nettype none

module cfir_dp #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cfir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cfir_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample_q,
    input  wire logic [cfir_pkg::IDX_W-1:0]        i_tap_index,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_tap_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_tap_im,
    input  wire cfir_pkg::t_dp_cmd                 i_cmd,
    output cfir_pkg::t_dp_status                   o_status,
    input  wire logic                              i_m_ready,
    output logic                                   o_m_valid,
    output cfir_pkg::t_acc                         o_out_i,
    output cfir_pkg::t_acc                         o_out_q
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW  = ($clog2(MAX_TAPS + 1) > cfir_pkg::CNT_W) ?
                         $clog2(MAX_TAPS + 1) : cfir_pkg::CNT_W;
    localparam int NW1 = NW + 1;
    localparam int PW  = 2 * SW + 1;
    localparam int DW  = 2 * SW;

    // configuration
    logic [cfir_pkg::CNT_W-1:0] r_tap_count;
    logic                       r_real_taps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= cfir_pkg::TAP_COUNT_RST;
            r_real_taps <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == cfir_pkg::REG_TAP_COUNT) begin
                r_tap_count <= i_cfg_wdata;
            end
            if (i_cfg_index == cfir_pkg::REG_REAL_TAPS) begin
                r_real_taps <= i_cfg_wdata[0];
            end
        end
    end

    // taps in use, capped at the store depth
    logic [NW-1:0] w_tc_ext;
    logic [NW-1:0] w_n;
    assign w_tc_ext = NW'(r_tap_count);
    assign w_n      = (w_tc_ext > NW'(MAX_TAPS)) ? NW'(MAX_TAPS) : w_tc_ext;

    // clearing sweep after reset
    logic [AW-1:0] r_clr_addr;
    logic          w_clr_last;
    assign w_clr_last = (r_clr_addr == AW'(MAX_TAPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en && !w_clr_last) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // circular write pointer of the delay line
    logic [AW-1:0] r_wp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.push_we) begin
            r_wp <= (r_wp == AW'(MAX_TAPS - 1)) ? '0 : r_wp + AW'(1);
        end
    end

    // tap store write side
    logic          w_idx_ok;
    logic          w_tp_we;
    logic [AW-1:0] w_tp_waddr;
    logic [DW-1:0] w_tp_wdata;
    assign w_idx_ok   = (int'(i_tap_index) < MAX_TAPS);
    assign w_tp_we    = i_cmd.clear_en || (i_cmd.load_we && w_idx_ok);
    assign w_tp_waddr = i_cmd.clear_en ? r_clr_addr : AW'(i_tap_index);
    assign w_tp_wdata = i_cmd.clear_en ? '0 : {i_tap_im, i_tap_re};

    // delay line write side
    logic          w_dl_we;
    logic [AW-1:0] w_dl_waddr;
    logic [DW-1:0] w_dl_wdata;
    assign w_dl_we    = i_cmd.clear_en || i_cmd.push_we;
    assign w_dl_waddr = i_cmd.clear_en ? r_clr_addr : r_wp;
    assign w_dl_wdata = i_cmd.clear_en ? '0 : {i_sample_q, i_sample_i};

    // read walk: oldest sample of the window against tap 0
    logic [NW1-1:0] w_wp_ext;
    logic [NW1-1:0] w_n_ext;
    logic [NW1-1:0] w_start;
    assign w_wp_ext = NW1'(r_wp);
    assign w_n_ext  = NW1'(w_n);
    assign w_start  = (w_wp_ext >= w_n_ext) ? (w_wp_ext - w_n_ext) :
                      (w_wp_ext + NW1'(MAX_TAPS) - w_n_ext);

    logic [AW-1:0] r_dl_raddr;
    logic [AW-1:0] r_tp_raddr;
    logic [NW-1:0] r_remain;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dl_raddr <= AW'(w_start);
            r_tp_raddr <= '0;
            r_remain   <= w_n;
        end else if (i_cmd.rd_en) begin
            r_dl_raddr <= (r_dl_raddr == AW'(MAX_TAPS - 1)) ? '0 : r_dl_raddr + AW'(1);
            r_tp_raddr <= r_tp_raddr + AW'(1);
            r_remain   <= r_remain - NW'(1);
        end
    end

    logic [DW-1:0] w_tp_rdata;
    logic [DW-1:0] w_dl_rdata;

    cfir_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tp_we),
        .i_waddr (w_tp_waddr),
        .i_wdata (w_tp_wdata),
        .i_raddr (r_tp_raddr),
        .o_rdata (w_tp_rdata)
    );

    cfir_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TAPS)
    ) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (w_dl_we),
        .i_waddr (w_dl_waddr),
        .i_wdata (w_dl_wdata),
        .i_raddr (r_dl_raddr),
        .o_rdata (w_dl_rdata)
    );

    // multiply stage
    logic signed [SW-1:0] w_xi;
    logic signed [SW-1:0] w_xq;
    logic signed [SW-1:0] w_hr;
    logic signed [SW-1:0] w_hi;
    assign w_xi = w_dl_rdata[SW-1:0];
    assign w_xq = w_dl_rdata[DW-1:SW];
    assign w_hr = w_tp_rdata[SW-1:0];
    assign w_hi = r_real_taps ? '0 : w_tp_rdata[DW-1:SW];

    logic                 r_v1;
    logic                 r_v2;
    logic signed [DW-1:0] r_p_ir;
    logic signed [DW-1:0] r_p_qi;
    logic signed [DW-1:0] r_p_ii;
    logic signed [DW-1:0] r_p_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_p_ir <= w_xi * w_hr;
            r_p_qi <= w_xq * w_hi;
            r_p_ii <= w_xi * w_hi;
            r_p_qr <= w_xq * w_hr;
        end
    end

    // accumulate stage, wraps at the accumulator width
    logic signed [PW-1:0] w_sum_i;
    logic signed [PW-1:0] w_sum_q;
    assign w_sum_i = PW'(r_p_ir) - PW'(r_p_qi);
    assign w_sum_q = PW'(r_p_ii) + PW'(r_p_qr);

    cfir_pkg::t_acc r_acc_i;
    cfir_pkg::t_acc r_acc_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_v2) begin
            r_acc_i <= r_acc_i + cfir_pkg::t_acc'(w_sum_i);
            r_acc_q <= r_acc_q + cfir_pkg::t_acc'(w_sum_q);
        end
    end

    // output register
    logic r_out_valid;
    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_i <= r_acc_i;
            o_out_q <= r_acc_q;
        end
    end

    assign o_m_valid = r_out_valid;

    assign o_status.clear_last = w_clr_last;
    assign o_status.n_zero     = (w_n == '0);
    assign o_status.rd_last    = (r_remain == NW'(1));
    assign o_status.pipe_busy  = r_v1 || r_v2;
    assign o_status.out_free   = w_out_free;

endmodule

`default_nettype wire

// ===== design/complex_fir_filter.sv =====
// top level of the streaming complex fir filter
//
// one stream channel in, one out. an input beat either loads a complex tap
// (tuser high, tap_index/tap_re/tap_im) or pushes a complex sample (tuser low,
// sample_i/sample_q). a load gives no output. a push gives one output beat:
// the sum over the active taps of tap[k] times the window sample k, window
// 0 being the oldest of the last tap_count samples. tap_count and real_taps
// are to be written on the config port while idle; the block does not
// enforce it. the active tap count is capped at MAX_TAPS; one shared
// complex multiply-accumulate walks the tap and delay stores one entry per
// cycle. a push with zero taps gives zero, as there is no walk. reset sets
// tap_count to 1 and real_taps low, then a sweep over all MAX_TAPS entries
// zeroes both stores with s_axis_tready low; config writes are still taken
// during the sweep. the result sits in an output register: a stalled
// receiver does not block loads or the next push, which only waits at its
// end for the register.
`default_nettype none

module complex_fir_filter #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config port
    input  wire logic                                  i_cfg_we,
    input  wire logic [cfir_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cfir_pkg::CNT_W-1:0]            i_cfg_wdata,
    // slave side
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // sample_i, sample_q, tap_index, tap_re, tap_im, zero padding
    input  wire logic [((4 * SAMPLE_WIDTH + cfir_pkg::IDX_W + 7) / 8) * 8 - 1:0]
                                                       s_axis_tdata,
    // action
    input  wire logic                                  s_axis_tuser,
    // master side
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // out_i, out_q
    output logic [cfir_pkg::OUT_W-1:0]                 m_axis_tdata
);

    localparam int SW = SAMPLE_WIDTH;

    // unpack the input beat
    logic signed [SW-1:0]             w_sample_i;
    logic signed [SW-1:0]             w_sample_q;
    logic [cfir_pkg::IDX_W-1:0]       w_tap_index;
    logic signed [SW-1:0]             w_tap_re;
    logic signed [SW-1:0]             w_tap_im;

    assign w_sample_i  = s_axis_tdata[SW-1:0];
    assign w_sample_q  = s_axis_tdata[2*SW-1:SW];
    assign w_tap_index = s_axis_tdata[2*SW+cfir_pkg::IDX_W-1:2*SW];
    assign w_tap_re    = s_axis_tdata[3*SW+cfir_pkg::IDX_W-1:2*SW+cfir_pkg::IDX_W];
    assign w_tap_im    = s_axis_tdata[4*SW+cfir_pkg::IDX_W-1:3*SW+cfir_pkg::IDX_W];

    cfir_pkg::t_dp_cmd    w_cmd;
    cfir_pkg::t_dp_status w_status;
    cfir_pkg::t_acc       w_out_i;
    cfir_pkg::t_acc       w_out_q;

    // sequencer: clearing sweep, accept, walk the taps, hand over the result
    cfir_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    // stores, multiply-accumulate and output register
    cfir_dp #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample_i  (w_sample_i),
        .i_sample_q  (w_sample_q),
        .i_tap_index (w_tap_index),
        .i_tap_re    (w_tap_re),
        .i_tap_im    (w_tap_im),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_out_i     (w_out_i),
        .o_out_q     (w_out_q)
    );

    // pack the output beat, out_i in the low half
    assign m_axis_tdata = {w_out_q, w_out_i};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the streaming complex fir filter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfir_pkg::*;

    localparam int MAX_TAPS     = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TDATA_W      = ((4 * SAMPLE_WIDTH + IDX_W + 7) / 8) * 8;
    localparam int ITEM_W       = 4 * SAMPLE_WIDTH + IDX_W;
    // margin for a push still in flight, through the walk and the output register
    localparam int SETTLE       = MAX_TAPS + 8;
    // cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1050;

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;

    // one input beat, last field in the lowest bits
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] tap_im;
        logic signed [SAMPLE_WIDTH-1:0] tap_re;
        logic [IDX_W-1:0]               tap_index;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
    } iq_item_t;

    // one output beat
    typedef struct packed {
        t_acc out_q;
        t_acc out_i;
    } fir_out_t;

    typedef enum logic [1:0] {
        ROW_PUSH,
        ROW_LOAD,
        ROW_CFG
    } row_kind_t;

    // directed row: v0/v1 are the sample or the tap, cfg_r is the raw real_taps word
    typedef struct packed {
        row_kind_t                      kind;
        logic signed [SAMPLE_WIDTH-1:0] v0;
        logic signed [SAMPLE_WIDTH-1:0] v1;
        logic [IDX_W-1:0]               idx;
        logic [CNT_W-1:0]               cfg_n;
        logic [CNT_W-1:0]               cfg_r;
        logic                           typed;
        t_acc                           exp_i;
        t_acc                           exp_q;
    } dir_row_t;

    localparam int N_ROWS = 24;

    // directed part: reset state, extremes, zero and oversized tap counts, real-tap mode
    localparam dir_row_t SCRIPT [N_ROWS] = '{
        // after reset: one tap, all taps zero
        '{ROW_PUSH, 16'sd1, 16'sd1, 6'd0, 7'd0, 7'd0, 1'b1, 40'sd0, 40'sd0},
        '{ROW_LOAD, S_MAX, S_MIN, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // unit sample picks the tap straight out
        '{ROW_PUSH, 16'sd1, 16'sd0, 6'd0, 7'd0, 7'd0, 1'b1, 40'sd32767, -40'sd32768},
        '{ROW_PUSH, S_MIN, S_MAX, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MAX, S_MIN, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // zero tap count: empty sum
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MAX, S_MAX, 6'd0, 7'd0, 7'd0, 1'b1, 40'sd0, 40'sd0},
        '{ROW_LOAD, S_MIN, S_MIN, 6'd63, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_LOAD, S_MAX, S_MAX, 6'd31, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // full length while most of the delay line is still empty
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd64, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MIN, S_MIN, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, -16'sd1, -16'sd1, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // oversized tap count saturates, upper bits of real_taps word ignored
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd127, 7'h7e, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MAX, S_MIN, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd65, 7'h01, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MIN, S_MAX, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, 16'sd0, 16'sd0, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // short filter in real-tap mode
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd2, 7'h7f, 1'b0, 40'sd0, 40'sd0},
        '{ROW_LOAD, S_MIN, S_MAX, 6'd1, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MIN, S_MIN, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MAX, S_MAX, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        // cleared tap gives zero
        '{ROW_CFG,  16'sd0, 16'sd0, 6'd0, 7'd1, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_LOAD, 16'sd0, 16'sd0, 6'd0, 7'd0, 7'd0, 1'b0, 40'sd0, 40'sd0},
        '{ROW_PUSH, S_MAX, S_MIN, 6'd0, 7'd0, 7'd0, 1'b1, 40'sd0, 40'sd0}
    };

    // dut ports, the inputs all known from time zero
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = REG_TAP_COUNT;
    logic [CNT_W-1:0]        i_cfg_wdata   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // sample_i, sample_q, tap_index, tap_re, tap_im, zero padding
    logic [TDATA_W-1:0]      s_axis_tdata  = '0;
    // action
    logic                    s_axis_tuser  = ACT_PUSH;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // out_i, out_q
    logic [OUT_W-1:0]        m_axis_tdata;

    complex_fir_filter #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // filter shadow: delay line, tap store and the two registers
    logic signed [SAMPLE_WIDTH-1:0] hist_i [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_q [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] coef_re [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] coef_im [MAX_TAPS];
    logic [CNT_W-1:0]               cfg_taps = TAP_COUNT_RST;
    logic                           cfg_real = 1'b0;

    // filter outputs still owed by the dut, oldest first
    fir_out_t owed_outputs [$];

    int  mismatches = 0;
    int  hang_count = 0;
    bit  steady     = 1'b0;   // no idling on either side while set

    fir_out_t got_out;
    fir_out_t want_out;

    initial begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            hist_i[k]  = '0;
            hist_q[k]  = '0;
            coef_re[k] = '0;
            coef_im[k] = '0;
        end
    end

    // shift a sample in and sum tap[k] * window[k], window[0] the oldest
    function automatic fir_out_t fir_push(input logic signed [SAMPLE_WIDTH-1:0] si,
                                          input logic signed [SAMPLE_WIDTH-1:0] sq);
        int       k;
        int       n;
        longint   xi, xq, hr, hi, acc_i, acc_q;
        fir_out_t res;
        for (k = 0; k < MAX_TAPS - 1; k++) begin
            hist_i[k] = hist_i[k+1];
            hist_q[k] = hist_q[k+1];
        end
        hist_i[MAX_TAPS-1] = si;
        hist_q[MAX_TAPS-1] = sq;
        n = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
        acc_i = 0;
        acc_q = 0;
        for (k = 0; k < n; k++) begin
            xi = hist_i[MAX_TAPS-n+k];
            xq = hist_q[MAX_TAPS-n+k];
            hr = coef_re[k];
            hi = cfg_real ? 0 : coef_im[k];
            acc_i += xi * hr - xq * hi;
            acc_q += xi * hi + xq * hr;
        end
        res.out_i = acc_i[ACC_W-1:0];
        res.out_q = acc_q[ACC_W-1:0];
        return res;
    endfunction

    // sample values with the extremes well represented
    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: begin
                return S_MAX;
            end
            1: begin
                return S_MIN;
            end
            2: begin
                return '0;
            end
            default: begin
                return SAMPLE_WIDTH'($urandom);
            end
        endcase
    endfunction

    // drive one beat from a falling edge, return at the falling edge after it is taken
    task automatic send_beat(input logic act, input iq_item_t item,
                             input bit typed, input fir_out_t typed_out);
        while (!steady && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(TDATA_W - ITEM_W){1'b0}}, item};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        // beat taken at this edge: update the shadow
        if (act == ACT_LOAD) begin
            coef_re[item.tap_index] = item.tap_re;
            coef_im[item.tap_index] = item.tap_im;
        end else begin
            want_out = fir_push(item.sample_i, item.sample_q);
            owed_outputs.push_back(typed ? typed_out : want_out);
        end
        @(negedge i_clk);
    endtask

    // both registers, once the block has drained and finished any last load
    task automatic write_regs(input logic [CNT_W-1:0] taps, input logic [CNT_W-1:0] real_word);
        s_axis_tvalid <= 1'b0;
        while (owed_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_TAP_COUNT;
        i_cfg_wdata <= taps;
        cfg_taps     = taps;
        @(negedge i_clk);
        i_cfg_index <= REG_REAL_TAPS;
        i_cfg_wdata <= real_word;
        cfg_real     = real_word[0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input fir_out_t want, input fir_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at %0t: out_i exp %0d got %0d, out_q exp %0d got %0d",
                     what, $realtime, want.out_i, got.out_i, want.out_q, got.out_q);
    endtask

    // receiver: not ready about 30 percent of the time except during the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // output checker, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_out = m_axis_tdata;
            if (owed_outputs.size() == 0) begin
                note_mismatch("unexpected beat", '0, got_out);
            end else begin
                want_out = owed_outputs.pop_front();
                if (got_out.out_i !== want_out.out_i || got_out.out_q !== want_out.out_q)
                    note_mismatch("data", want_out, got_out);
            end
        end
    end

    // watchdog: cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

    // stimulus
    initial begin
        int               row;
        int               sent;
        int               phase;
        int               len;
        int               n_eff;
        int               sel;
        logic             act;
        logic [CNT_W-1:0] n_cfg;
        logic [CNT_W-1:0] r_cfg;
        iq_item_t         item;
        fir_out_t         typed_out;

        // hold reset, then release it; the dut sweeps its stores with tready low
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (row = 0; row < N_ROWS; row++) begin
            item            = '0;
            typed_out.out_i = SCRIPT[row].exp_i;
            typed_out.out_q = SCRIPT[row].exp_q;
            case (SCRIPT[row].kind)
                ROW_CFG: begin
                    write_regs(SCRIPT[row].cfg_n, SCRIPT[row].cfg_r);
                end
                ROW_LOAD: begin
                    item.tap_index = SCRIPT[row].idx;
                    item.tap_re    = SCRIPT[row].v0;
                    item.tap_im    = SCRIPT[row].v1;
                    send_beat(ACT_LOAD, item, 1'b0, typed_out);
                end
                default: begin
                    item.sample_i = SCRIPT[row].v0;
                    item.sample_q = SCRIPT[row].v1;
                    send_beat(ACT_PUSH, item, SCRIPT[row].typed, typed_out);
                end
            endcase
        end

        // random phases, each with its own register setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            // a long stretch with no idling on either side
            steady = (phase >= 4 && phase < 8);
            // mostly short filters, a few full-length and oversized ones
            sel = $urandom_range(0, 99);
            if (sel < 55)
                n_cfg = CNT_W'($urandom_range(1, 8));
            else if (sel < 75)
                n_cfg = CNT_W'($urandom_range(9, 32));
            else if (sel < 83)
                n_cfg = CNT_W'($urandom_range(33, 63));
            else if (sel < 88)
                n_cfg = CNT_W'(MAX_TAPS);
            else if (sel < 95)
                n_cfg = CNT_W'($urandom_range(MAX_TAPS + 1, 127));
            else
                n_cfg = '0;
            r_cfg = CNT_W'($urandom);
            write_regs(n_cfg, r_cfg);
            n_eff = (n_cfg > MAX_TAPS) ? MAX_TAPS : int'(n_cfg);

            len = $urandom_range(30, 70);
            for (int j = 0; j < len; j++) begin
                item.sample_i  = pick_value();
                item.sample_q  = pick_value();
                item.tap_re    = pick_value();
                item.tap_im    = pick_value();
                item.tap_index = IDX_W'($urandom);
                act = ($urandom_range(0, 99) < 25) ? ACT_LOAD : ACT_PUSH;
                // loads mostly land on taps that are in use
                if (act == ACT_LOAD && n_eff > 0 && $urandom_range(0, 99) < 70)
                    item.tap_index = IDX_W'($urandom_range(0, n_eff - 1));
                send_beat(act, item, 1'b0, '0);
                sent++;
            end
        end

        // drain, then allow for a last push still in flight
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (owed_outputs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cfir_pkg.sv
design/cfir_ram.sv
design/cfir_ctrl.sv
design/cfir_dp.sv
design/complex_fir_filter.sv
tb/tb.sv
